// File: hw/rtl/gehf_pkg.sv
package gehf_pkg;

  // Fixed-point formats
  localparam int HEADING_FRAC_BITS = 28;
  localparam int ENC_FRAC_BITS     = 13;
  localparam int ENC_SHIFT         = HEADING_FRAC_BITS - ENC_FRAC_BITS;
  // 1e6 * 2^(32-F) = 15625 * 2^ZSHIFT, so the power-of-two part is a shift
  localparam int ZSHIFT            = 6 + 32 - HEADING_FRAC_BITS;

  localparam int HEAD_W = 31;
  localparam int VAL_W  = 35;
  localparam int DIFF_W = 34;
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 32;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // Multiplier constants
  localparam logic [31:0] DEG2RAD_Q32 = 32'd74960064;
  localparam logic [31:0] DIV_ODD     = 32'd15625;
  localparam logic [63:0] RECIP_L     = (64'd1 << 45) / 64'd15625;
  localparam logic [31:0] RECIP_Q45   = RECIP_L[31:0];

  // Quotient correction thresholds (estimate is low by at most four)
  localparam logic [16:0] REM_T1 = 17'(DIV_ODD);
  localparam logic [16:0] REM_T2 = 17'(2 * DIV_ODD);
  localparam logic [16:0] REM_T3 = 17'(3 * DIV_ODD);
  localparam logic [16:0] REM_T4 = 17'(4 * DIV_ODD);

  // Wrap limits, rounded to nearest
  localparam logic [63:0] PI_L =
    ((64'd314159 << HEADING_FRAC_BITS) + 64'd50000) / 64'd100000;
  localparam logic [63:0] TWO_PI_L =
    ((64'd628318 << HEADING_FRAC_BITS) + 64'd50000) / 64'd100000;
  localparam logic signed [VAL_W-1:0] PI_Q     = $signed(PI_L[VAL_W-1:0]);
  localparam logic signed [VAL_W-1:0] NEG_PI_Q = -PI_Q;
  localparam logic signed [VAL_W-1:0] TWO_PI_Q = $signed(TWO_PI_L[VAL_W-1:0]);

  // Register indexes on the config port
  typedef enum logic [1:0] {
    REG_DEADBAND,
    REG_GAIN_POS,
    REG_GAIN_NEG,
    REG_GYRO_WEIGHT
  } reg_idx_t;

  // Microcode
  localparam int STEP_W = 5;
  typedef logic [STEP_W-1:0] step_t;
  localparam step_t STEP_IDLE = 5'd0;
  localparam step_t STEP_DIFF = 5'd10;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_MAG_GAIN,
    MUL_DEG,
    MUL_YL_T,
    MUL_YH_T,
    MUL_RECIP,
    MUL_QDIV,
    MUL_WEIGHT
  } mul_sel_t;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_SAVE_Y,
    ACT_SAVE_ZL,
    ACT_SAVE_Z,
    ACT_SAVE_Q,
    ACT_SAVE_R,
    ACT_X,
    ACT_DIFF,
    ACT_ABS,
    ACT_BLEND,
    ACT_WRAP,
    ACT_OUT
  } act_t;

  typedef enum logic [2:0] {
    BR_NEXT,
    BR_JUMP,
    BR_WAIT_IN,
    BR_DEAD,
    BR_OUT
  } br_t;

  typedef struct packed {
    mul_sel_t mul;
    act_t     act;
    br_t      br;
    step_t    target;
  } ctrl_word_t;

  typedef struct packed {
    logic in_fire;
    logic dead;
    logic out_free;
  } seq_status_t;

  // Program ROM: one control word per step
  function automatic ctrl_word_t ucode_rom(input step_t addr);
    ctrl_word_t cw;
    case (addr)
      5'd0:  cw = '{MUL_NONE,     ACT_NONE,    BR_WAIT_IN, STEP_IDLE};
      5'd1:  cw = '{MUL_MAG_GAIN, ACT_NONE,    BR_DEAD,    STEP_DIFF};
      5'd2:  cw = '{MUL_DEG,      ACT_NONE,    BR_NEXT,    STEP_IDLE};
      5'd3:  cw = '{MUL_YL_T,     ACT_SAVE_Y,  BR_NEXT,    STEP_IDLE};
      5'd4:  cw = '{MUL_YH_T,     ACT_SAVE_ZL, BR_NEXT,    STEP_IDLE};
      5'd5:  cw = '{MUL_NONE,     ACT_SAVE_Z,  BR_NEXT,    STEP_IDLE};
      5'd6:  cw = '{MUL_RECIP,    ACT_NONE,    BR_NEXT,    STEP_IDLE};
      5'd7:  cw = '{MUL_QDIV,     ACT_SAVE_Q,  BR_NEXT,    STEP_IDLE};
      5'd8:  cw = '{MUL_NONE,     ACT_SAVE_R,  BR_NEXT,    STEP_IDLE};
      5'd9:  cw = '{MUL_NONE,     ACT_X,       BR_NEXT,    STEP_IDLE};
      5'd10: cw = '{MUL_NONE,     ACT_DIFF,    BR_NEXT,    STEP_IDLE};
      5'd11: cw = '{MUL_NONE,     ACT_ABS,     BR_NEXT,    STEP_IDLE};
      5'd12: cw = '{MUL_WEIGHT,   ACT_NONE,    BR_NEXT,    STEP_IDLE};
      5'd13: cw = '{MUL_NONE,     ACT_BLEND,   BR_NEXT,    STEP_IDLE};
      5'd14: cw = '{MUL_NONE,     ACT_WRAP,    BR_NEXT,    STEP_IDLE};
      5'd15: cw = '{MUL_NONE,     ACT_WRAP,    BR_NEXT,    STEP_IDLE};
      5'd16: cw = '{MUL_NONE,     ACT_OUT,     BR_OUT,     STEP_IDLE};
      default: cw = '{MUL_NONE,   ACT_NONE,    BR_JUMP,    STEP_IDLE};
    endcase
    return cw;
  endfunction

endpackage

// File: hw/rtl/gehf_useq.sv
module gehf_useq import gehf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  seq_status_t status,
  output ctrl_word_t  cw
);

  step_t step_r;
  step_t step_nxt;

  // Control word for the current step
  assign cw = ucode_rom(step_r);

  // Step counter with conditional jumps
  always_comb begin
    case (cw.br)
      BR_NEXT:    step_nxt = step_r + 5'd1;
      BR_JUMP:    step_nxt = cw.target;
      BR_WAIT_IN: step_nxt = status.in_fire ? step_r + 5'd1 : step_r;
      BR_DEAD:    step_nxt = status.dead ? cw.target : step_r + 5'd1;
      BR_OUT:     step_nxt = status.out_free ? cw.target : step_r;
      default:    step_nxt = STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

// File: hw/rtl/gyro_encoder_heading_fusion.sv
// Each item runs the microcode program from input accept to out_tvalid, with a shorter path
// when |gyro_rate| is under the deadband. One item at a time: in_tready stays low until the result
// is handed to the output register, which waits on any output stall. Each multiply takes one step on the single
// shared 33x32 multiplier, and the divide by 1e6 is a reciprocal multiply plus correction.
// Reset (rst_n low, synchronous): config registers to defaults, fused heading to zero,
// sequencer back to its wait step, output empty.
module gyro_encoder_heading_fusion import gehf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // gyro_rate[15:0], encoder_heading[31:16], step_time_us[47:32]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // heading[30:0], zero pad [31]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  // Config registers
  logic [14:0] deadband_r;
  logic [15:0] gain_pos_r;
  logic [15:0] gain_neg_r;
  logic [15:0] gyro_weight_r;

  // Item registers
  logic [15:0]              mag_r,  mag_nxt;
  logic                     neg_r,  neg_nxt;
  logic                     dead_r, dead_nxt;
  logic [15:0]              gain_r, gain_nxt;
  logic signed [15:0]       enc_r,  enc_nxt;
  logic [15:0]              t_r,    t_nxt;

  // Datapath registers
  logic [PROD_W-1:0]        prod_r, prod_nxt;
  logic [7:0]               yh_r,   yh_nxt;
  logic [47:0]              zlo_r,  zlo_nxt;
  logic [45:0]              zs_r,   zs_nxt;
  logic [31:0]              q_r,    q_nxt;
  logic [16:0]              rem_r,  rem_nxt;
  logic [31:0]              x_r,    x_nxt;
  logic signed [DIFF_W-1:0] d_r,    d_nxt;
  logic                     dneg_r, dneg_nxt;
  logic [MUL_A_W-1:0]       dmag_r, dmag_nxt;
  logic signed [VAL_W-1:0]  v_r,    v_nxt;
  logic signed [HEAD_W-1:0] fused_r, fused_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [HEAD_W-1:0]        out_heading_r, out_heading_nxt;

  // Control
  ctrl_word_t  cw;
  seq_status_t status;
  logic        in_fire;
  logic        out_free;

  // Combinational helpers
  logic [15:0]              rate_in;
  logic [15:0]              rate_mag;
  logic [MUL_A_W-1:0]       mul_a;
  logic [MUL_B_W-1:0]       mul_b;
  logic [PROD_W-1:0]        mul_p;
  logic [55:0]              zsum;
  logic [55:0]              zsum_sh;
  logic [45:0]              rem_full;
  logic [2:0]               corr;
  logic signed [DIFF_W-1:0] enc_ext;
  logic signed [DIFF_W-1:0] enc_q;
  logic signed [DIFF_W-1:0] x_ext;
  logic signed [DIFF_W-1:0] x_signed;
  logic signed [DIFF_W-1:0] d_neg;
  logic signed [50:0]       wp_ext;
  logic signed [50:0]       wp_signed;
  logic signed [50:0]       enc_sh;
  logic signed [50:0]       blend_sum;
  logic signed [VAL_W-1:0]  v_wrap;
  logic signed [VAL_W-1:0]  v_clamp;

  gehf_useq u_useq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .cw     (cw)
  );

  // Handshake
  assign in_tready  = (cw.br == BR_WAIT_IN);
  assign in_fire    = in_tvalid & in_tready;
  assign out_free   = ~out_valid_r | out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_heading_r};

  assign status = '{in_fire: in_fire, dead: dead_r, out_free: out_free};

  // Input unpack and rate magnitude
  assign rate_in  = in_tdata[15:0];
  assign rate_mag = rate_in[15] ? (~rate_in + 16'd1) : rate_in;

  // Shared multiplier operand select
  always_comb begin
    case (cw.mul)
      MUL_MAG_GAIN: begin
        mul_a = {17'b0, mag_r};
        mul_b = {16'b0, gain_r};
      end
      MUL_DEG: begin
        mul_a = {2'b0, prod_r[30:0]};
        mul_b = DEG2RAD_Q32;
      end
      MUL_YL_T: begin
        mul_a = {1'b0, prod_r[49:18]};
        mul_b = {16'b0, t_r};
      end
      MUL_YH_T: begin
        mul_a = {25'b0, yh_r};
        mul_b = {16'b0, t_r};
      end
      MUL_RECIP: begin
        mul_a = {1'b0, zs_r[45:14]};
        mul_b = RECIP_Q45;
      end
      MUL_QDIV: begin
        mul_a = {1'b0, prod_r[62:31]};
        mul_b = DIV_ODD;
      end
      MUL_WEIGHT: begin
        mul_a = dmag_r;
        mul_b = {16'b0, gyro_weight_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Increment: (y * t) >> ZSHIFT, y split at bit 32
  assign zsum    = 56'(zlo_r) + {prod_r[23:0], 32'd0};
  assign zsum_sh = zsum >> ZSHIFT;

  // Remainder against the quotient estimate, then the small correction
  assign rem_full = zs_r - prod_r[45:0];
  assign corr = 3'(rem_r >= REM_T1) + 3'(rem_r >= REM_T2)
              + 3'(rem_r >= REM_T3) + 3'(rem_r >= REM_T4);

  // Difference gyro path minus encoder, both Q3.F
  assign enc_ext  = DIFF_W'(enc_r);
  assign enc_q    = enc_ext <<< ENC_SHIFT;
  assign x_ext    = $signed({2'b0, x_r});
  assign x_signed = neg_r ? -x_ext : x_ext;
  assign d_neg    = -d_r;

  // Blend: 2^16 * enc + w * (gyro - enc), rounded half up
  assign wp_ext    = $signed({2'b0, prod_r[48:0]});
  assign wp_signed = dneg_r ? -wp_ext : wp_ext;
  assign enc_sh    = 51'(enc_q) <<< 16;
  assign blend_sum = wp_signed + enc_sh + 51'sd32768;

  // Wrap by one turn, and the final clamp
  always_comb begin
    if (v_r > PI_Q) begin
      v_wrap = v_r - TWO_PI_Q;
    end else if (v_r < NEG_PI_Q) begin
      v_wrap = v_r + TWO_PI_Q;
    end else begin
      v_wrap = v_r;
    end
  end

  always_comb begin
    if (v_r > PI_Q) begin
      v_clamp = PI_Q;
    end else if (v_r < NEG_PI_Q) begin
      v_clamp = NEG_PI_Q;
    end else begin
      v_clamp = v_r;
    end
  end

  // Datapath next values
  always_comb begin
    mag_nxt         = mag_r;
    neg_nxt         = neg_r;
    dead_nxt        = dead_r;
    gain_nxt        = gain_r;
    enc_nxt         = enc_r;
    t_nxt           = t_r;
    prod_nxt        = prod_r;
    yh_nxt          = yh_r;
    zlo_nxt         = zlo_r;
    zs_nxt          = zs_r;
    q_nxt           = q_r;
    rem_nxt         = rem_r;
    x_nxt           = x_r;
    d_nxt           = d_r;
    dneg_nxt        = dneg_r;
    dmag_nxt        = dmag_r;
    v_nxt           = v_r;
    fused_nxt       = fused_r;
    out_valid_nxt   = out_valid_r;
    out_heading_nxt = out_heading_r;

    // capture a new item; zero increment unless the gyro path runs
    if (in_fire) begin
      mag_nxt  = rate_mag;
      neg_nxt  = rate_in[15] | (rate_in == 16'd0);
      dead_nxt = rate_mag < {1'b0, deadband_r};
      gain_nxt = (rate_in[15] | (rate_in == 16'd0)) ? gain_neg_r : gain_pos_r;
      enc_nxt  = $signed(in_tdata[31:16]);
      t_nxt    = in_tdata[47:32];
      x_nxt    = '0;
    end

    if (cw.mul != MUL_NONE) begin
      prod_nxt = mul_p;
    end

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (cw.act)
      ACT_SAVE_Y:  yh_nxt  = prod_r[57:50];
      ACT_SAVE_ZL: zlo_nxt = prod_r[47:0];
      ACT_SAVE_Z:  zs_nxt  = zsum_sh[45:0];
      ACT_SAVE_Q:  q_nxt   = prod_r[62:31];
      ACT_SAVE_R:  rem_nxt = rem_full[16:0];
      ACT_X:       x_nxt   = q_r + 32'(corr);
      ACT_DIFF:    d_nxt   = DIFF_W'(fused_r) + x_signed - enc_q;
      ACT_ABS: begin
        dneg_nxt = d_r[DIFF_W-1];
        dmag_nxt = d_r[DIFF_W-1] ? d_neg[MUL_A_W-1:0] : d_r[MUL_A_W-1:0];
      end
      ACT_BLEND:   v_nxt   = blend_sum[50:16];
      ACT_WRAP:    v_nxt   = v_wrap;
      ACT_OUT: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_heading_nxt = v_clamp[HEAD_W-1:0];
          fused_nxt       = v_clamp[HEAD_W-1:0];
        end
      end
      default: ;
    endcase
  end

  // Config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadband_r    <= 15'd19;
      gain_pos_r    <= 16'd16384;
      gain_neg_r    <= 16'd16384;
      gyro_weight_r <= 16'd65470;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_DEADBAND:    deadband_r    <= cfg_wdata[14:0];
        REG_GAIN_POS:    gain_pos_r    <= cfg_wdata;
        REG_GAIN_NEG:    gain_neg_r    <= cfg_wdata;
        REG_GYRO_WEIGHT: gyro_weight_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fused_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fused_r     <= fused_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    mag_r         <= mag_nxt;
    neg_r         <= neg_nxt;
    dead_r        <= dead_nxt;
    gain_r        <= gain_nxt;
    enc_r         <= enc_nxt;
    t_r           <= t_nxt;
    prod_r        <= prod_nxt;
    yh_r          <= yh_nxt;
    zlo_r         <= zlo_nxt;
    zs_r          <= zs_nxt;
    q_r           <= q_nxt;
    rem_r         <= rem_nxt;
    x_r           <= x_nxt;
    d_r           <= d_nxt;
    dneg_r        <= dneg_nxt;
    dmag_r        <= dmag_nxt;
    v_r           <= v_nxt;
    out_heading_r <= out_heading_nxt;
  end

endmodule

// File: hw/rtl/gehf_checker.sv
module gehf_checker import gehf_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // Heading stays inside the wrap limits, pad bit clear
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[31] && ($signed(out_tdata[30:0]) <= PI_Q)
                   && ($signed(out_tdata[30:0]) >= NEG_PI_Q))
    else $error("heading out of range");

  // One item at a time: ready stays low after an accept, checked over part of the shortest program path
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready ##1 !in_tready ##1 !in_tready
      ##1 !in_tready ##1 !in_tready ##1 !in_tready ##1 !in_tready)
    else $error("item accepted while busy");

  // Reset empties the output and returns to the wait step
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("bad state after reset");

endmodule

bind gyro_encoder_heading_fusion gehf_checker u_gehf_checker (.*);
